// ===== hw/rtl/gta_pkg.sv =====
// Shared types, constants and helpers for the gemm tile accumulator.
// Standalone; used by gta_fmul, gta_fadd and gemm_tile_accumulate.
`timescale 1ns / 1ps

package gta_pkg;

    localparam int DEF_TILE_ROWS = 6;
    localparam int DEF_TILE_COLS = 8;
    localparam int MAX_COLS      = 8;
    localparam int DBL_W         = 64;

    localparam logic [DBL_W-1:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
    localparam logic [DBL_W-1:0] DBL_ONE   = 64'h3FF0_0000_0000_0000;

    typedef enum logic {
        CMD_STEP   = 1'b0,
        CMD_FINISH = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd              command;
        logic [2:0]        row;
        logic [DBL_W-1:0]  a_value;
        logic [DBL_W-1:0]  operand_0;
        logic [DBL_W-1:0]  operand_1;
        logic [DBL_W-1:0]  operand_2;
        logic [DBL_W-1:0]  operand_3;
        logic [DBL_W-1:0]  operand_4;
        logic [DBL_W-1:0]  operand_5;
        logic [DBL_W-1:0]  operand_6;
        logic [DBL_W-1:0]  operand_7;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        out_row;
        logic [DBL_W-1:0]  new_c_0;
        logic [DBL_W-1:0]  new_c_1;
        logic [DBL_W-1:0]  new_c_2;
        logic [DBL_W-1:0]  new_c_3;
        logic [DBL_W-1:0]  new_c_4;
        logic [DBL_W-1:0]  new_c_5;
        logic [DBL_W-1:0]  new_c_6;
        logic [DBL_W-1:0]  new_c_7;
    } t_out_item;

    // Leading-zero count from the top bit; callers pad the low end with ones.
    function automatic logic [6:0] lzc128(input logic [127:0] v);
        logic [6:0] n;
        logic       found;
        n     = 7'd0;
        found = 1'b0;
        for (int i = 127; i >= 0; i--) begin
            if (!found) begin
                if (v[i]) begin
                    found = 1'b1;
                end else begin
                    n = n + 7'd1;
                end
            end
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/gta_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module gta_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

// ===== hw/rtl/gta_fmul.sv =====
// Pipelined binary64 multiplier, round to nearest even, five stages.
// Depends on gta_pkg.
`timescale 1ns / 1ps

module gta_fmul (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [gta_pkg::DBL_W-1:0] i_a,
    input  logic [gta_pkg::DBL_W-1:0] i_b,
    output logic [gta_pkg::DBL_W-1:0] o_p
);

    // Stage 1: unpack, specials, four partial products
    logic        sa, sb, nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic [10:0] eea, eeb;
    logic [52:0] ma, mb;
    logic        r1_s, r1_nan, r1_inf, r1_zero;
    logic signed [12:0] r1_x;
    logic [53:0] r1_ll;
    logic [52:0] r1_lh, r1_hl;
    logic [51:0] r1_hh;

    always_comb begin
        sa     = i_a[63];
        sb     = i_b[63];
        nan_a  = (i_a[62:52] == 11'h7FF) && (i_a[51:0] != '0);
        nan_b  = (i_b[62:52] == 11'h7FF) && (i_b[51:0] != '0);
        inf_a  = (i_a[62:52] == 11'h7FF) && (i_a[51:0] == '0);
        inf_b  = (i_b[62:52] == 11'h7FF) && (i_b[51:0] == '0);
        zero_a = (i_a[62:0] == '0);
        zero_b = (i_b[62:0] == '0);
        eea    = (i_a[62:52] == '0) ? 11'd1 : i_a[62:52];
        eeb    = (i_b[62:52] == '0) ? 11'd1 : i_b[62:52];
        ma     = {(i_a[62:52] != '0), i_a[51:0]};
        mb     = {(i_b[62:52] != '0), i_b[51:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_s    <= sa ^ sb;
            r1_nan  <= nan_a | nan_b | (inf_a & zero_b) | (inf_b & zero_a);
            r1_inf  <= inf_a | inf_b;
            r1_zero <= zero_a | zero_b;
            r1_x    <= $signed({2'b0, eea}) + $signed({2'b0, eeb}) - 13'sd1023;
            r1_ll   <= ma[26:0]  * mb[26:0];
            r1_lh   <= 53'(ma[26:0]  * mb[52:27]);
            r1_hl   <= 53'(ma[52:27] * mb[26:0]);
            r1_hh   <= ma[52:27] * mb[52:27];
        end
    end

    // Stage 2: full 106-bit product
    logic [105:0] r2_p;
    logic         r2_s, r2_nan, r2_inf, r2_zero;
    logic signed [12:0] r2_x;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_p    <= {r1_hh, 54'b0} + {26'b0, r1_lh, 27'b0}
                     + {26'b0, r1_hl, 27'b0} + {52'b0, r1_ll};
            r2_s    <= r1_s;
            r2_nan  <= r1_nan;
            r2_inf  <= r1_inf;
            r2_zero <= r1_zero;
            r2_x    <= r1_x;
        end
    end

    // Stage 3: leading-zero count
    logic [105:0] r3_p;
    logic [6:0]   r3_lz;
    logic         r3_s, r3_nan, r3_inf, r3_zero;
    logic signed [12:0] r3_x;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_lz   <= gta_pkg::lzc128({r2_p, 22'h3F_FFFF});
            r3_p    <= r2_p;
            r3_s    <= r2_s;
            r3_nan  <= r2_nan;
            r3_inf  <= r2_inf;
            r3_zero <= r2_zero;
            r3_x    <= r2_x;
        end
    end

    // Stage 4: normalize, or denormalize when the exponent runs below one
    logic         neg, full;
    logic [12:0]  rs;
    logic [6:0]   rsc, lsh;
    logic [211:0] wide;
    logic [105:0] left, sh;
    logic [52:0]  r4_m;
    logic         r4_g, r4_st, r4_s, r4_nan, r4_inf, r4_zero;
    logic [11:0]  r4_eb;

    always_comb begin
        neg  = (r3_x < 0);
        full = (r3_x >= $signed({6'b0, r3_lz}));
        rs   = 13'(-r3_x);
        rsc  = (rs > 13'd106) ? 7'd106 : rs[6:0];
        lsh  = full ? r3_lz : r3_x[6:0];
        wide = {r3_p, 106'b0} >> rsc;
        left = r3_p << lsh;
        sh   = neg ? wide[211:106] : left;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_m    <= sh[105:53];
            r4_g    <= sh[52];
            r4_st   <= (|sh[51:0]) | (neg & (|wide[105:0]));
            r4_eb   <= (!neg && full) ? 12'(r3_x - $signed({6'b0, r3_lz})) : 12'd0;
            r4_s    <= r3_s;
            r4_nan  <= r3_nan;
            r4_inf  <= r3_inf;
            r4_zero <= r3_zero;
        end
    end

    // Stage 5: round; carry out of the mantissa bumps the exponent
    logic        inc;
    logic [63:0] rnd;
    logic [63:0] r5_p;

    always_comb begin
        inc = r4_g & (r4_st | r4_m[0]);
        rnd = {r4_eb, 52'b0} + {11'b0, r4_m} + {63'b0, inc};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            priority if (r4_nan) begin
                r5_p <= gta_pkg::CANON_NAN;
            end else if (r4_inf || rnd[63:52] >= 12'd2047) begin
                r5_p <= {r4_s, 11'h7FF, 52'b0};
            end else if (r4_zero) begin
                r5_p <= {r4_s, 63'b0};
            end else begin
                r5_p <= {r4_s, rnd[62:0]};
            end
        end
    end

    assign o_p = r5_p;

endmodule

// ===== hw/rtl/gta_fadd.sv =====
// Pipelined binary64 adder, round to nearest even; four registered stages
// followed by a combinational normalize-and-round stage. Depends on gta_pkg.
`timescale 1ns / 1ps

module gta_fadd (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [gta_pkg::DBL_W-1:0] i_x,
    input  logic [gta_pkg::DBL_W-1:0] i_y,
    output logic [gta_pkg::DBL_W-1:0] o_s
);

    // Stage 1: unpack, order by magnitude, exponent difference
    logic        swp, nan_x, nan_y, inf_x, inf_y;
    logic [63:0] big, sml;
    logic [10:0] eb, es;
    logic [52:0] r1_mb, r1_ms;
    logic [10:0] r1_e, r1_d;
    logic        r1_sub, r1_s, r1_nan, r1_inf, r1_zs;

    always_comb begin
        nan_x = (i_x[62:52] == 11'h7FF) && (i_x[51:0] != '0);
        nan_y = (i_y[62:52] == 11'h7FF) && (i_y[51:0] != '0);
        inf_x = (i_x[62:52] == 11'h7FF) && (i_x[51:0] == '0);
        inf_y = (i_y[62:52] == 11'h7FF) && (i_y[51:0] == '0);
        swp   = (i_y[62:0] > i_x[62:0]);
        big   = swp ? i_y : i_x;
        sml   = swp ? i_x : i_y;
        eb    = (big[62:52] == '0) ? 11'd1 : big[62:52];
        es    = (sml[62:52] == '0) ? 11'd1 : sml[62:52];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mb  <= {(big[62:52] != '0), big[51:0]};
            r1_ms  <= {(sml[62:52] != '0), sml[51:0]};
            r1_e   <= eb;
            r1_d   <= eb - es;
            r1_sub <= big[63] ^ sml[63];
            r1_s   <= big[63];
            r1_nan <= nan_x | nan_y | (inf_x & inf_y & (i_x[63] ^ i_y[63]));
            r1_inf <= inf_x | inf_y;
            r1_zs  <= i_x[63] & i_y[63];
        end
    end

    // Stage 2: align the smaller operand, keeping guard, round and sticky
    logic [5:0]   dc;
    logic [111:0] al;
    logic [55:0]  r2_big, r2_sml;
    logic [10:0]  r2_e;
    logic         r2_sub, r2_s, r2_nan, r2_inf, r2_zs;

    always_comb begin
        dc = (r1_d > 11'd56) ? 6'd56 : r1_d[5:0];
        al = {r1_ms, 3'b0, 56'b0} >> dc;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_big <= {r1_mb, 3'b0};
            r2_sml <= {al[111:57], al[56] | (|al[55:0])};
            r2_e   <= r1_e;
            r2_sub <= r1_sub;
            r2_s   <= r1_s;
            r2_nan <= r1_nan;
            r2_inf <= r1_inf;
            r2_zs  <= r1_zs;
        end
    end

    // Stage 3: magnitude add or subtract
    logic [56:0] r3_sum;
    logic [10:0] r3_e;
    logic        r3_s, r3_nan, r3_inf, r3_zs;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_sum <= r2_sub ? ({1'b0, r2_big} - {1'b0, r2_sml})
                             : ({1'b0, r2_big} + {1'b0, r2_sml});
            r3_e   <= r2_e;
            r3_s   <= r2_s;
            r3_nan <= r2_nan;
            r3_inf <= r2_inf;
            r3_zs  <= r2_zs;
        end
    end

    // Stage 4: leading-zero count of the sum
    logic [56:0] r4_sum;
    logic [6:0]  r4_lz;
    logic [10:0] r4_e;
    logic        r4_s, r4_nan, r4_inf, r4_zs;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_lz  <= gta_pkg::lzc128({r3_sum, 71'h7F_FFFF_FFFF_FFFF_FFFF});
            r4_sum <= r3_sum;
            r4_e   <= r3_e;
            r4_s   <= r3_s;
            r4_nan <= r3_nan;
            r4_inf <= r3_inf;
            r4_zs  <= r3_zs;
        end
    end

    // Stage 5: normalize (never below the minimum exponent), then round
    logic [6:0]  lzm1, sh;
    logic [10:0] emax;
    logic [55:0] n;
    logic [11:0] ebase;
    logic        inc;
    logic [63:0] rnd;

    always_comb begin
        lzm1 = r4_lz - 7'd1;
        emax = r4_e - 11'd1;
        sh   = ({4'b0, lzm1} <= emax) ? lzm1 : emax[6:0];
        if (r4_sum[56]) begin
            n     = {r4_sum[56:2], r4_sum[1] | r4_sum[0]};
            ebase = {1'b0, r4_e};
        end else begin
            n     = r4_sum[55:0] << sh;
            ebase = {1'b0, emax} - {5'b0, sh};
        end
        inc = n[2] & ((|n[1:0]) | n[3]);
        rnd = {ebase, 52'b0} + {11'b0, n[55:3]} + {63'b0, inc};
    end

    always_comb begin
        priority if (r4_nan) begin
            o_s = gta_pkg::CANON_NAN;
        end else if (r4_inf || rnd[63:52] >= 12'd2047) begin
            o_s = {r4_s, 11'h7FF, 52'b0};
        end else if (r4_sum == '0) begin
            o_s = {r4_zs, 63'b0};
        end else begin
            o_s = {r4_s, rnd[62:0]};
        end
    end

endmodule

// ===== hw/rtl/gemm_tile_accumulate.sv =====
// Top level of the gemm tile accumulator: lanes, row memory, hazard control.
// Depends on gta_pkg, gta_ram, gta_fmul and gta_fadd.
`timescale 1ns / 1ps
//
//  channel | direction | signals                    | moves
//  --------+-----------+----------------------------+---------------------------------
//  input   | in        | i_valid, o_ready, i_item   | step or finish for one tile row
//  result  | out       | o_valid, i_ready, o_result | finished C row
//
//  One transaction per cycle while no held result stalls the pipeline and no
//  row is reused while its previous transaction is still at or before the row
//  read; otherwise the row's read-modify-write interlock holds o_ready low
//  until that transaction is past its read. o_valid rises for a finish once
//  the accepted item has passed five multiply stages, four adder stages and
//  the result register; the row read overlaps the last multiply stage. Sync
//  reset clears control and row valid bits; the partial-sum memory itself is
//  not swept. A held result stalls the whole pipeline.

module gemm_tile_accumulate #(
    parameter int TILE_ROWS = gta_pkg::DEF_TILE_ROWS,
    parameter int TILE_COLS = gta_pkg::DEF_TILE_COLS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  gta_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output gta_pkg::t_out_item o_result
);

    localparam int ROW_AW  = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
    localparam int RD_STG  = 4;
    localparam int WB_STG  = 9;
    localparam int HZ_LAST = WB_STG - RD_STG - 1;
    localparam int DW      = gta_pkg::DBL_W;
    localparam int MC      = gta_pkg::MAX_COLS;

    // Stage control
    logic               r_v   [WB_STG+1];
    gta_pkg::t_cmd      r_cmd [WB_STG+1];
    logic [2:0]         r_row [WB_STG+1];
    logic [DW-1:0]      r_a;
    logic [DW-1:0]      r_b   [TILE_COLS];
    logic [TILE_ROWS-1:0] r_rowv;
    logic               r_rdv;
    logic               r_ov;
    gta_pkg::t_out_item r_out;

    logic               w_adv, w_hz, w_acc, w_inrange;
    logic [DW-1:0]      w_opnd [MC];
    logic [DW-1:0]      w_prod [TILE_COLS];
    logic [DW-1:0]      w_ps   [TILE_COLS];
    logic [DW-1:0]      w_sum  [TILE_COLS];
    logic [DW-1:0]      w_newc [MC];
    logic [TILE_COLS*DW-1:0] w_q, w_wdata;

    assign w_opnd[0] = i_item.operand_0;
    assign w_opnd[1] = i_item.operand_1;
    assign w_opnd[2] = i_item.operand_2;
    assign w_opnd[3] = i_item.operand_3;
    assign w_opnd[4] = i_item.operand_4;
    assign w_opnd[5] = i_item.operand_5;
    assign w_opnd[6] = i_item.operand_6;
    assign w_opnd[7] = i_item.operand_7;

    // Interlock: a row still at or before its read stage blocks entry
    always_comb begin
        w_hz = 1'b0;
        for (int k = 0; k <= HZ_LAST; k++) begin
            if (r_v[k] && r_row[k] == i_item.row) begin
                w_hz = 1'b1;
            end
        end
    end

    assign w_adv     = !r_ov || i_ready;
    assign o_ready   = w_adv && !w_hz;
    assign w_acc     = i_valid && o_ready;
    assign w_inrange = (32'(i_item.row) < TILE_ROWS);

    // Stage line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= WB_STG; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_v[0] <= w_acc && w_inrange;
            for (int k = 1; k <= WB_STG; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cmd[0] <= i_item.command;
            r_row[0] <= i_item.row;
            // A finish multiplies the operands by one, which is exact
            r_a <= (i_item.command == gta_pkg::CMD_FINISH) ? gta_pkg::DBL_ONE
                                                            : i_item.a_value;
            for (int k = 1; k <= WB_STG; k++) begin
                r_cmd[k] <= r_cmd[k-1];
                r_row[k] <= r_row[k-1];
            end
        end
    end

    // Row valid bits: a row never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rowv <= '0;
            r_rdv  <= 1'b0;
        end else if (w_adv) begin
            if (r_v[WB_STG]) begin
                r_rowv[ROW_AW'(r_row[WB_STG])] <= 1'b1;
            end
            r_rdv <= r_v[RD_STG] ? r_rowv[ROW_AW'(r_row[RD_STG])] : 1'b0;
        end
    end

    gta_ram #(
        .WIDTH (TILE_COLS*DW),
        .DEPTH (TILE_ROWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_adv && r_v[WB_STG]),
        .i_waddr (ROW_AW'(r_row[WB_STG])),
        .i_wdata (w_wdata),
        .i_re    (w_adv),
        .i_raddr (ROW_AW'(r_row[RD_STG])),
        .o_rdata (w_q)
    );

    // Column lanes
    for (genvar j = 0; j < TILE_COLS; j++) begin : g_lane
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_b[j] <= w_opnd[j];
            end
        end

        gta_fmul u_mul (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_a   (r_a),
            .i_b   (r_b[j]),
            .o_p   (w_prod[j])
        );

        assign w_ps[j] = r_rdv ? w_q[j*DW +: DW] : '0;

        gta_fadd u_add (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_x   (w_ps[j]),
            .i_y   (w_prod[j]),
            .o_s   (w_sum[j])
        );

        // A finish clears the row
        assign w_wdata[j*DW +: DW] =
            (r_cmd[WB_STG] == gta_pkg::CMD_FINISH) ? '0 : w_sum[j];
    end

    for (genvar j = 0; j < MC; j++) begin : g_col
        if (j < TILE_COLS) begin : g_used
            assign w_newc[j] = w_sum[j];
        end else begin : g_unused
            assign w_newc[j] = '0;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_ov <= r_v[WB_STG] && (r_cmd[WB_STG] == gta_pkg::CMD_FINISH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out.out_row <= r_row[WB_STG];
            r_out.new_c_0 <= w_newc[0];
            r_out.new_c_1 <= w_newc[1];
            r_out.new_c_2 <= w_newc[2];
            r_out.new_c_3 <= w_newc[3];
            r_out.new_c_4 <= w_newc[4];
            r_out.new_c_5 <= w_newc[5];
            r_out.new_c_6 <= w_newc[6];
            r_out.new_c_7 <= w_newc[7];
        end
    end

    assign o_valid  = r_ov;
    assign o_result = r_out;

    // Checks
    a_wb_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[WB_STG] |-> (32'(r_row[WB_STG]) < TILE_ROWS))
        else $error("write-back to a row outside the tile");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_v[RD_STG] && r_v[WB_STG] |-> r_row[RD_STG] != r_row[WB_STG])
        else $error("row read while its write-back is pending");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_v[WB_STG] && r_cmd[WB_STG] == gta_pkg::CMD_FINISH))
        else $error("result raised without a finish transaction");

endmodule
